/* rtl/bam_pkg.sv */
// ----------------------------------------------------------------------------
// bam_pkg
// Shared types and constants of the box area downscaler.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int NUM_CHAN  = 4;
  localparam int CH_W      = 8;
  localparam int SUM_W     = 34;
  localparam int SCFG_W    = 14;
  localparam int DCFG_W    = 13;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_IDX_W = 12;
  localparam int LANE_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  typedef struct packed {
    logic [CH_W-1:0] chan_0;
    logic [CH_W-1:0] chan_1;
    logic [CH_W-1:0] chan_2;
    logic [CH_W-1:0] chan_3;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]      avg_0;
    logic [CH_W-1:0]      avg_1;
    logic [CH_W-1:0]      avg_2;
    logic [CH_W-1:0]      avg_3;
    logic [OUT_IDX_W-1:0] out_col;
    logic [OUT_IDX_W-1:0] out_row;
    logic                 frame_done;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_C0_GO,
    ST_C0_WT,
    ST_R0_GO,
    ST_R0_WT,
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_SUM_GO,
    ST_SUM_WT,
    ST_EMIT,
    ST_ADV,
    ST_CMUL,
    ST_CB_GO,
    ST_CB_WT,
    ST_RMUL,
    ST_RB_GO,
    ST_RB_WT
  } st_t;

  typedef enum logic [1:0] {
    MUL_CNT,
    MUL_CBAND,
    MUL_RBAND
  } mul_op_t;

  typedef enum logic [2:0] {
    DIV_COL0,
    DIV_ROW0,
    DIV_SUM,
    DIV_CBAND,
    DIV_RBAND
  } div_op_t;

  typedef struct packed {
    logic              clr;
    logic              take;
    logic              acc;
    logic              mul_en;
    mul_op_t           mul_op;
    logic              div_go;
    div_op_t           div_op;
    logic [LANE_W-1:0] lane;
    logic              emit;
    logic              adv;
  } ctl_cmd_t;

  typedef struct packed {
    logic restart;
    logic clr_last;
    logic div_done;
    logic band_done;
    logic cdiv_need;
    logic rdiv_need;
    logic out_full;
  } dp_sts_t;

endpackage

/* rtl/bam_ram.sv */
// ----------------------------------------------------------------------------
// bam_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bam_div.sv */
// ----------------------------------------------------------------------------
// bam_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bam_div #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W:0]       rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dvs_r;
  logic [W:0]       rem_sh;
  logic             ge;
  logic [W:0]       rem_nxt;
  logic [W-1:0]     quo_nxt;

  always_comb begin
    rem_sh  = {rem_r[W-1:0], quo_r[W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
    quo_nxt = {quo_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/bam_ctrl.sv */
// ----------------------------------------------------------------------------
// bam_ctrl
// Sequencer: clearing pass, band setup, per-pixel accumulate, average, advance.
// ----------------------------------------------------------------------------
module bam_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bam_pkg::dp_sts_t  sts,
  output bam_pkg::ctl_cmd_t cmd
);

  import bam_pkg::*;

  st_t               st_r, st_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      lane_r <= '0;
    end else begin
      st_r   <= st_nxt;
      lane_r <= lane_nxt;
    end
  end

  // next state
  always_comb begin
    st_nxt   = st_r;
    lane_nxt = lane_r;
    unique case (st_r)
      ST_CLEAR:  if (sts.clr_last) st_nxt = ST_C0_GO;
      ST_C0_GO:  st_nxt = ST_C0_WT;
      ST_C0_WT:  if (sts.div_done) st_nxt = ST_R0_GO;
      ST_R0_GO:  st_nxt = ST_R0_WT;
      ST_R0_WT:  if (sts.div_done) st_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) st_nxt = ST_ACC;
      ST_ACC:    st_nxt = sts.band_done ? ST_MUL : ST_ADV;
      ST_MUL: begin
        lane_nxt = '0;
        st_nxt   = ST_SUM_GO;
      end
      ST_SUM_GO: st_nxt = ST_SUM_WT;
      ST_SUM_WT: begin
        if (sts.div_done) begin
          if (lane_r == LANE_W'(NUM_CHAN - 1)) begin
            st_nxt = ST_EMIT;
          end else begin
            lane_nxt = lane_r + LANE_W'(1);
            st_nxt   = ST_SUM_GO;
          end
        end
      end
      ST_EMIT:   if (!sts.out_full) st_nxt = ST_ADV;
      ST_ADV: begin
        if (sts.cdiv_need) st_nxt = ST_CMUL;
        else if (sts.rdiv_need) st_nxt = ST_RMUL;
        else st_nxt = ST_IDLE;
      end
      ST_CMUL:   st_nxt = ST_CB_GO;
      ST_CB_GO:  st_nxt = ST_CB_WT;
      ST_CB_WT:  if (sts.div_done) st_nxt = ST_IDLE;
      ST_RMUL:   st_nxt = ST_RB_GO;
      ST_RB_GO:  st_nxt = ST_RB_WT;
      ST_RB_WT:  if (sts.div_done) st_nxt = ST_IDLE;
      default:   st_nxt = ST_CLEAR;
    endcase
    if (sts.restart) st_nxt = ST_CLEAR;
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.lane = lane_r;
    in_ready = 1'b0;
    unique case (st_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_C0_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DIV_COL0;
      end
      ST_R0_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DIV_ROW0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_ACC: cmd.acc = 1'b1;
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_CNT;
      end
      ST_SUM_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DIV_SUM;
      end
      ST_EMIT: cmd.emit = !sts.out_full;
      ST_ADV:  cmd.adv = 1'b1;
      ST_CMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_CBAND;
      end
      ST_CB_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DIV_CBAND;
      end
      ST_RMUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_RBAND;
      end
      ST_RB_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_op = DIV_RBAND;
      end
      default: cmd.lane = lane_r;
    endcase
  end

endmodule

/* rtl/bam_dp.sv */
// ----------------------------------------------------------------------------
// bam_dp
// Datapath: config registers, positions and bands, accumulator line,
// multiplier, shared divider and output register.
// ----------------------------------------------------------------------------
module bam_dp #(
  parameter int MAX_SRC_DIM = 8192,
  parameter int MAX_DST_DIM = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bam_pkg::in_item_t                in_data,
  input  logic                             cfg_we,
  input  logic [bam_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bam_pkg::SCFG_W-1:0]       cfg_wdata,
  input  bam_pkg::ctl_cmd_t                cmd,
  output bam_pkg::dp_sts_t                 sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output bam_pkg::out_item_t               out_data
);

  import bam_pkg::*;

  localparam int SRCC_W = $clog2(MAX_SRC_DIM + 1);
  localparam int SRCP_W = $clog2(MAX_SRC_DIM);
  localparam int DSTC_W = $clog2(MAX_DST_DIM + 1);
  localparam int DSTP_W = (MAX_DST_DIM > 1) ? $clog2(MAX_DST_DIM) : 1;
  localparam int PROD_W = 2 * SRCC_W;
  localparam int DIV_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam int ROW_W  = NUM_CHAN * SUM_W;

  function automatic logic [31:0] clamp_dim(logic [31:0] v, logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) r = 32'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // configuration
  logic [SCFG_W-1:0] cfg_sw_r, cfg_sh_r;
  logic [DCFG_W-1:0] cfg_dw_r, cfg_dh_r;
  logic              cfg_hit;

  always_comb begin
    unique case (cfg_idx) inside
      REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sw_r <= SCFG_W'(1);
      cfg_sh_r <= SCFG_W'(1);
      cfg_dw_r <= DCFG_W'(1);
      cfg_dh_r <= DCFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SRC_WIDTH:  cfg_sw_r <= cfg_wdata;
        REG_SRC_HEIGHT: cfg_sh_r <= cfg_wdata;
        REG_DST_WIDTH:  cfg_dw_r <= cfg_wdata[DCFG_W-1:0];
        REG_DST_HEIGHT: cfg_dh_r <= cfg_wdata[DCFG_W-1:0];
        default: cfg_sw_r <= cfg_sw_r;
      endcase
    end
  end

  // effective sizes
  logic [31:0]       sw32, sh32, dwhi, dhhi;
  logic [SRCC_W-1:0] sw_r, sh_r;
  logic [DSTC_W-1:0] dw_r, dh_r;

  always_comb begin
    sw32 = clamp_dim(32'(cfg_sw_r), 32'(MAX_SRC_DIM));
    sh32 = clamp_dim(32'(cfg_sh_r), 32'(MAX_SRC_DIM));
    dwhi = (sw32 < 32'(MAX_DST_DIM)) ? sw32 : 32'(MAX_DST_DIM);
    dhhi = (sh32 < 32'(MAX_DST_DIM)) ? sh32 : 32'(MAX_DST_DIM);
  end

  always_ff @(posedge clk) begin
    sw_r <= SRCC_W'(sw32);
    sh_r <= SRCC_W'(sh32);
    dw_r <= DSTC_W'(clamp_dim(32'(cfg_dw_r), dwhi));
    dh_r <= DSTC_W'(clamp_dim(32'(cfg_dh_r), dhhi));
  end

  // positions and bands
  logic [SRCP_W-1:0] src_col_r, src_row_r;
  logic [DSTP_W-1:0] dst_col_r, dst_row_r, clr_addr_r;
  logic [SRCC_W-1:0] cbb_r, cbe_r, rbb_r, rbe_r, col0_r, row0_r;
  logic              col_end, row_end, col_wrap, row_wrap;

  always_comb begin
    col_end  = 32'(src_col_r) + 32'd1 >= 32'(cbe_r);
    row_end  = 32'(src_row_r) + 32'd1 >= 32'(rbe_r);
    col_wrap = 32'(src_col_r) + 32'd1 >= 32'(sw_r);
    row_wrap = 32'(src_row_r) + 32'd1 >= 32'(sh_r);
  end

  // divider
  div_op_t          div_op_r;
  logic [DIV_W-1:0] div_a, div_b, div_q;
  logic             div_done;
  logic [PROD_W-1:0] prod_r;
  logic [ROW_W-1:0]  sums_r;

  always_comb begin
    unique case (cmd.div_op)
      DIV_COL0: begin
        div_a = DIV_W'(sw_r);
        div_b = DIV_W'(dw_r);
      end
      DIV_ROW0: begin
        div_a = DIV_W'(sh_r);
        div_b = DIV_W'(dh_r);
      end
      DIV_SUM: begin
        div_a = DIV_W'(sums_r[cmd.lane * SUM_W +: SUM_W]);
        div_b = DIV_W'(prod_r);
      end
      DIV_CBAND: begin
        div_a = DIV_W'(prod_r);
        div_b = DIV_W'(dw_r);
      end
      DIV_RBAND: begin
        div_a = DIV_W'(prod_r);
        div_b = DIV_W'(dh_r);
      end
      default: begin
        div_a = '0;
        div_b = DIV_W'(1);
      end
    endcase
  end

  bam_div #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_go) div_op_r <= cmd.div_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      src_col_r  <= '0;
      src_row_r  <= '0;
      dst_col_r  <= '0;
      dst_row_r  <= '0;
      cbb_r      <= '0;
      rbb_r      <= '0;
      cbe_r      <= '0;
      rbe_r      <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.clr) clr_addr_r <= clr_addr_r + DSTP_W'(1);
      if (cmd.adv) begin
        if (col_wrap) begin
          src_col_r <= '0;
          dst_col_r <= '0;
          cbb_r     <= '0;
          cbe_r     <= col0_r;
          if (row_wrap) begin
            src_row_r <= '0;
            dst_row_r <= '0;
            rbb_r     <= '0;
            rbe_r     <= row0_r;
          end else begin
            src_row_r <= src_row_r + SRCP_W'(1);
            if (row_end) begin
              dst_row_r <= dst_row_r + DSTP_W'(1);
              rbb_r     <= rbe_r;
            end
          end
        end else begin
          src_col_r <= src_col_r + SRCP_W'(1);
          if (col_end) begin
            dst_col_r <= dst_col_r + DSTP_W'(1);
            cbb_r     <= cbe_r;
          end
        end
      end
      if (div_done) begin
        unique case (div_op_r)
          DIV_COL0:  cbe_r <= SRCC_W'(div_q);
          DIV_ROW0:  rbe_r <= SRCC_W'(div_q);
          DIV_CBAND: cbe_r <= SRCC_W'(div_q);
          DIV_RBAND: rbe_r <= SRCC_W'(div_q);
          default:   cbe_r <= cbe_r;
        endcase
      end
    end
  end

  // first boundaries, averages
  logic [CH_W-1:0] avg_r [NUM_CHAN];

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (div_op_r)
        DIV_COL0: col0_r <= SRCC_W'(div_q);
        DIV_ROW0: row0_r <= SRCC_W'(div_q);
        DIV_SUM:  avg_r[cmd.lane] <= div_q[CH_W-1:0];
        default:  col0_r <= col0_r;
      endcase
    end
  end

  // multiplier
  logic [SRCC_W-1:0] mul_a, mul_b;

  always_comb begin
    unique case (cmd.mul_op)
      MUL_CNT: begin
        mul_a = cbe_r - cbb_r;
        mul_b = rbe_r - rbb_r;
      end
      MUL_CBAND: begin
        mul_a = SRCC_W'(32'(dst_col_r) + 32'd1);
        mul_b = sw_r;
      end
      MUL_RBAND: begin
        mul_a = SRCC_W'(32'(dst_row_r) + 32'd1);
        mul_b = sh_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // accumulator line
  in_item_t         pix_r;
  logic [CH_W-1:0]  pix_ch [NUM_CHAN];
  logic [ROW_W-1:0] row_rd, sum_nxt, mem_wdata;
  logic [DSTP_W-1:0] mem_waddr;

  always_ff @(posedge clk) begin
    if (cmd.take) pix_r <= in_data;
  end

  always_comb begin
    pix_ch[0] = pix_r.chan_0;
    pix_ch[1] = pix_r.chan_1;
    pix_ch[2] = pix_r.chan_2;
    pix_ch[3] = pix_r.chan_3;
    for (int i = 0; i < NUM_CHAN; i++) begin
      sum_nxt[i * SUM_W +: SUM_W] = row_rd[i * SUM_W +: SUM_W] + SUM_W'(pix_ch[i]);
    end
    mem_waddr = cmd.clr ? clr_addr_r : dst_col_r;
    mem_wdata = (cmd.clr || (col_end && row_end)) ? '0 : sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) sums_r <= sum_nxt;
  end

  bam_ram #(.WIDTH(ROW_W), .DEPTH(MAX_DST_DIM)) u_line (
    .clk   (clk),
    .we    (cmd.clr || cmd.acc),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (dst_col_r),
    .rdata (row_rd)
  );

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.avg_0      <= avg_r[0];
      out_data_r.avg_1      <= avg_r[1];
      out_data_r.avg_2      <= avg_r[2];
      out_data_r.avg_3      <= avg_r[3];
      out_data_r.out_col    <= OUT_IDX_W'(dst_col_r);
      out_data_r.out_row    <= OUT_IDX_W'(dst_row_r);
      out_data_r.frame_done <= (32'(dst_col_r) + 32'd1 == 32'(dw_r)) &&
                               (32'(dst_row_r) + 32'd1 == 32'(dh_r));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.restart   = cfg_hit;
    sts.clr_last  = clr_addr_r == DSTP_W'(MAX_DST_DIM - 1);
    sts.div_done  = div_done;
    sts.band_done = col_end && row_end;
    sts.cdiv_need = !col_wrap && col_end;
    sts.rdiv_need = col_wrap && row_end && !row_wrap;
    sts.out_full  = out_valid_r && !out_ready;
  end

endmodule

/* rtl/box_area_downscaler.sv */
// ----------------------------------------------------------------------------
// box_area_downscaler
// Area-average image downscaler for four-channel raster pixel streams.
// ----------------------------------------------------------------------------
// Source pixels enter one at a time in raster order; each output pixel is the
// truncated mean of its source box, delivered when the box's last pixel
// arrives. A pixel that closes no column band is only accumulated. Closing a column
// band (or, at a line end, a row band) adds a multiply and one pass of the
// shared bit-serial divider, DIV_W = 34 bits wide at default sizes. A pixel
// that completes a box adds four divides, one per channel, plus any wait for
// the output register to free up. The divider is the limit. After reset and
// after every register write, the accumulator line is cleared, then the first
// band ends are computed (two divides) before input is taken again.
module box_area_downscaler #(
  parameter int MAX_SRC_DIM = 8192,
  parameter int MAX_DST_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bam_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bam_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [bam_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bam_pkg::SCFG_W-1:0]    cfg_wdata
);

  import bam_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bam_dp #(
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .MAX_DST_DIM (MAX_DST_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* sim/tb_box_area_downscaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_area_downscaler
// Self-checking bench for the box area downscaler.
// ----------------------------------------------------------------------------
// Pixel requests are fed from a queue by a clocked driver. A predictor of the
// band accumulation and averaging computes each expected output pixel when its
// request is accepted. A clocked monitor compares the outputs in order. The
// size registers are rewritten between phases: small frames, saturating and
// zero sizes, and wide and tall frames sent in part.
module tb_box_area_downscaler;
  import bam_pkg::*;

  localparam int DST_LIM   = 4096;
  localparam int SRC_LIM   = 8192;
  localparam int SETTLE    = 400;
  localparam int CYC_LIMIT = 3000000;

  localparam int PAT_RANDOM = 0;
  localparam int PAT_ZERO   = 1;
  localparam int PAT_ONES   = 2;
  localparam int PAT_ALT    = 3;

  logic               clk;
  logic               rst_n;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_SRC_WIDTH;
  logic [SCFG_W-1:0]  cfg_wdata = '0;

  box_area_downscaler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  in_item_t  pixel_q[$];
  out_item_t avg_q[$];
  int        errors = 0;
  bit        quiet = 0;
  int        hold_req = 0;
  int        pushed = 0;

  // predictor state
  int unsigned       reg_sw, reg_sh, reg_dw, reg_dh;
  int unsigned       s_col, s_row, d_col, d_row;
  int unsigned       cb_lo, cb_hi, rb_lo, rb_hi;
  logic [SUM_W-1:0]  box_sum[DST_LIM][NUM_CHAN];

  function automatic int unsigned eff_src(int unsigned v);
    return (v < 1) ? 1 : (v > SRC_LIM) ? SRC_LIM : v;
  endfunction

  function automatic int unsigned eff_dst(int unsigned v, int unsigned s);
    int unsigned hi;
    hi = (s < DST_LIM) ? s : DST_LIM;
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned band_hi(int unsigned i, int unsigned s, int unsigned d);
    return int'((longint'(i) + 1) * s / d);
  endfunction

  function automatic void restart_frame();
    int unsigned sw, sh;
    sw = eff_src(reg_sw);
    sh = eff_src(reg_sh);
    s_col = 0; d_col = 0; cb_lo = 0; cb_hi = band_hi(0, sw, eff_dst(reg_dw, sw));
    s_row = 0; d_row = 0; rb_lo = 0; rb_hi = band_hi(0, sh, eff_dst(reg_dh, sh));
    foreach (box_sum[i, c]) box_sum[i][c] = '0;
  endfunction

  function automatic void predict_pixel(in_item_t px);
    int unsigned sw, sh, dw, dh;
    longint unsigned cnt;
    logic [CH_W-1:0] ch[NUM_CHAN];
    logic [CH_W-1:0] av[NUM_CHAN];
    out_item_t r;
    sw = eff_src(reg_sw);
    sh = eff_src(reg_sh);
    dw = eff_dst(reg_dw, sw);
    dh = eff_dst(reg_dh, sh);
    ch[0] = px.chan_0; ch[1] = px.chan_1; ch[2] = px.chan_2; ch[3] = px.chan_3;
    if (d_col < DST_LIM) begin
      for (int c = 0; c < NUM_CHAN; c++) box_sum[d_col][c] = box_sum[d_col][c] + ch[c];
      if (s_col + 1 >= cb_hi) begin
        if (s_row + 1 >= rb_hi) begin
          cnt = longint'(cb_hi - cb_lo) * longint'(rb_hi - rb_lo);
          if (cnt == 0) cnt = 1;
          for (int c = 0; c < NUM_CHAN; c++) begin
            av[c] = CH_W'(longint'(box_sum[d_col][c]) / cnt);
            box_sum[d_col][c] = '0;
          end
          r.avg_0 = av[0]; r.avg_1 = av[1]; r.avg_2 = av[2]; r.avg_3 = av[3];
          r.out_col = OUT_IDX_W'(d_col);
          r.out_row = OUT_IDX_W'(d_row);
          r.frame_done = (d_col + 1 == dw) && (d_row + 1 == dh);
          avg_q.push_back(r);
        end
        d_col++;
        cb_lo = cb_hi;
        cb_hi = band_hi(d_col, sw, dw);
      end
    end
    s_col++;
    if (s_col >= sw) begin
      s_col = 0; d_col = 0; cb_lo = 0; cb_hi = band_hi(0, sw, dw);
      if (s_row + 1 >= rb_hi) begin
        d_row++;
        rb_lo = rb_hi;
        rb_hi = band_hi(d_row, sh, dh);
      end
      s_row++;
      if (s_row >= sh) begin
        s_row = 0; d_row = 0; rb_lo = 0; rb_hi = band_hi(0, sh, dh);
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR t=%0t %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // request driver
  int gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    nv = in_valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_pixel(in_data);
        nv = 1'b0;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          nv = 1'b0;
        end else if (pixel_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 5);
          nv = 1'b0;
        end else if (pixel_q.size() > 0) begin
          nv = 1'b1;
          in_data <= pixel_q.pop_front();
        end
      end
    end
    in_valid <= nv;
  end

  // receiver: random stalls plus one long hold-off
  int stall_left = 0;
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 3000;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and timeout
  int cyc = 0;
  always @(posedge clk) begin
    out_item_t e;
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("box_area_downscaler: mismatch");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (avg_q.size() == 0) begin
        report_mismatch("unexpected output, out_col", out_data.out_col, -1);
      end else begin
        e = avg_q.pop_front();
        if (out_data.avg_0 !== e.avg_0) report_mismatch("avg_0", out_data.avg_0, e.avg_0);
        if (out_data.avg_1 !== e.avg_1) report_mismatch("avg_1", out_data.avg_1, e.avg_1);
        if (out_data.avg_2 !== e.avg_2) report_mismatch("avg_2", out_data.avg_2, e.avg_2);
        if (out_data.avg_3 !== e.avg_3) report_mismatch("avg_3", out_data.avg_3, e.avg_3);
        if (out_data.out_col !== e.out_col)
          report_mismatch("out_col", out_data.out_col, e.out_col);
        if (out_data.out_row !== e.out_row)
          report_mismatch("out_row", out_data.out_row, e.out_row);
        if (out_data.frame_done !== e.frame_done)
          report_mismatch("frame_done", out_data.frame_done, e.frame_done);
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pixel_q.size() > 0 || in_valid || avg_q.size() > 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= SCFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:  reg_sw = val & 14'h3FFF;
      REG_SRC_HEIGHT: reg_sh = val & 14'h3FFF;
      REG_DST_WIDTH:  reg_dw = val & 13'h1FFF;
      REG_DST_HEIGHT: reg_dh = val & 13'h1FFF;
      default: ;
    endcase
    restart_frame();
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic set_size(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
  endtask

  task automatic push_pixels(int n, int pat);
    in_item_t px;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      case (pat)
        PAT_ZERO: px = '0;
        PAT_ONES: px = '1;
        PAT_ALT:  px = (i % 2) ? '1 : '0;
        default:  px = in_item_t'($urandom);
      endcase
      pixel_q.push_back(px);
      pushed++;
    end
  endtask

  initial begin
    int unsigned sw, sh, dw, dh, n;
    reg_sw = 1; reg_sh = 1; reg_dw = 1; reg_dh = 1;
    restart_frame();
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // directed
    push_pixels(3, PAT_ALT);
    set_size(2, 2, 1, 1);
    push_pixels(4, PAT_ONES);
    push_pixels(4, PAT_ZERO);
    set_size(0, 0, 0, 0);
    push_pixels(3, PAT_RANDOM);
    set_size(3, 2, 5, 7);
    push_pixels(6, PAT_RANDOM);
    set_size(16383, 1, 8191, 1);
    push_pixels(20, PAT_RANDOM);
    set_size(3, 16383, 3, 8191);
    push_pixels(12, PAT_ONES);
    set_size(8192, 8192, 4096, 4096);
    push_pixels(6, PAT_RANDOM);

    // long receiver hold-off with one output per pixel
    set_size(4, 4, 4, 4);
    @(negedge clk);
    hold_req++;
    push_pixels(32, PAT_RANDOM);

    // sender pause mid-frame
    set_size(6, 4, 3, 2);
    push_pixels(10, PAT_RANDOM);
    wait_drained();
    push_pixels(14, PAT_RANDOM);

    while (pushed < 760) begin
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 10);
      dw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, sw);
      dh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, sh);
      set_size(sw, sh, dw, dh);
      n = sw * sh * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) n = n + $urandom_range(1, sw * sh);
      push_pixels(n, PAT_RANDOM);
    end

    // last part without idling
    set_size(8, 6, 3, 4);
    @(negedge clk);
    quiet = 1;
    push_pixels(96, PAT_RANDOM);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("box_area_downscaler: match");
    end else begin
      $display("box_area_downscaler: mismatch");
    end
    $finish;
  end

endmodule
